@@ rtl/xenc_pkg.sv @@
// Shared types, opcode constants and helper functions of the instruction encoder.
package xenc_pkg;

  localparam int unsigned MaxBytes = 10;
  localparam int unsigned ByteIdxW = 4;

  typedef enum logic [5:0] {
    CMD_MOV_RR       = 6'd0,
    CMD_MOV_R_STK    = 6'd1,
    CMD_MOV_R_PTR    = 6'd2,
    CMD_MOV_STK_R    = 6'd3,
    CMD_MOV_R_IMM64  = 6'd4,
    CMD_MOV_PTR_R    = 6'd5,
    CMD_MOVZX_R8     = 6'd6,
    CMD_MOVSX_R8     = 6'd7,
    CMD_MOVZX_R16    = 6'd8,
    CMD_MOVSX_R16    = 6'd9,
    CMD_MOV_R32      = 6'd10,
    CMD_MOVSXD       = 6'd11,
    CMD_MOVZX_B_PTR  = 6'd12,
    CMD_MOVZX_W_PTR  = 6'd13,
    CMD_MOV_R32_PTR  = 6'd14,
    CMD_MOV_R64_PTR  = 6'd15,
    CMD_CMP_IMM8     = 6'd16,
    CMD_CMP_RR       = 6'd17,
    CMD_CMP_R_STK    = 6'd18,
    CMD_CALL_R       = 6'd19,
    CMD_CALL_REL     = 6'd20,
    CMD_SYSCALL      = 6'd21,
    CMD_ADD_RR       = 6'd22,
    CMD_ADD_IMM      = 6'd23,
    CMD_SUB_RR       = 6'd24,
    CMD_SUB_IMM      = 6'd25,
    CMD_IMUL_RR      = 6'd26,
    CMD_IMUL_IMM     = 6'd27,
    CMD_IDIV         = 6'd28,
    CMD_LEA_STK      = 6'd29,
    CMD_LEA_RIP      = 6'd30,
    CMD_CQO          = 6'd31,
    CMD_JMP          = 6'd32,
    CMD_JE           = 6'd33,
    CMD_JNE          = 6'd34,
    CMD_JG           = 6'd35,
    CMD_JGE          = 6'd36,
    CMD_JL           = 6'd37,
    CMD_JLE          = 6'd38,
    CMD_RET          = 6'd39
  } cmd_e;

  localparam logic [7:0] OpMovStore  = 8'h89;
  localparam logic [7:0] OpMovLoad   = 8'h8B;
  localparam logic [7:0] OpMovImm    = 8'hB8;
  localparam logic [7:0] SibRsp      = 8'h24;
  localparam logic [7:0] OpAluImm32  = 8'h81;
  localparam logic [7:0] OpAluImm8   = 8'h83;
  localparam logic [7:0] OpImulImm8  = 8'h6B;
  localparam logic [7:0] OpImulImm32 = 8'h69;
  localparam logic [7:0] OpCallRel   = 8'hE8;
  localparam logic [7:0] OpJmpRel    = 8'hE9;
  localparam logic [7:0] OpGrp3      = 8'hF7;
  localparam logic [7:0] OpCqo       = 8'h99;
  localparam logic [7:0] OpEscape    = 8'h0F;
  localparam logic [7:0] OpMovzxB    = 8'hB6;
  localparam logic [7:0] OpMovsxB    = 8'hBE;
  localparam logic [7:0] OpMovzxW    = 8'hB7;
  localparam logic [7:0] OpMovsxW    = 8'hBF;
  localparam logic [7:0] OpMovsxd    = 8'h63;
  localparam logic [7:0] OpCmpStore  = 8'h39;
  localparam logic [7:0] OpCmpLoad   = 8'h3B;
  localparam logic [7:0] OpGrp5      = 8'hFF;
  localparam logic [7:0] OpSyscall2  = 8'h05;
  localparam logic [7:0] OpAddStore  = 8'h01;
  localparam logic [7:0] OpSubStore  = 8'h29;
  localparam logic [7:0] OpImul2     = 8'hAF;
  localparam logic [7:0] OpLea       = 8'h8D;
  localparam logic [7:0] RexW        = 8'h48;
  localparam logic [7:0] OpJe        = 8'h84;
  localparam logic [7:0] OpJne       = 8'h85;
  localparam logic [7:0] OpJg        = 8'h8F;
  localparam logic [7:0] OpJge       = 8'h8D;
  localparam logic [7:0] OpJl        = 8'h8C;
  localparam logic [7:0] OpJle       = 8'h8E;
  localparam logic [7:0] OpRet       = 8'hC3;
  localparam logic [31:0] Disp8Max   = 32'd127;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [ByteIdxW-1:0]      count;
    logic                     rel_en;
    logic [ByteIdxW-1:0]      rel_pos;
  } desc_t;

  function automatic logic [7:0] rex(input logic w, input logic [3:0] r, input logic [3:0] b);
    return {4'h4, w, r[3], 1'b0, b[3]};
  endfunction

  function automatic logic [7:0] modrm(input logic [1:0] mode, input logic [2:0] reg_f,
                                       input logic [2:0] rm);
    return {mode, reg_f, rm};
  endfunction

endpackage

@@ rtl/xenc_front.sv @@
// Front end: accepts instruction beats and decodes each into its full byte sequence.
module xenc_front
  import xenc_pkg::*;
(
  input  logic         s_valid_i,
  output logic         s_ready_o,
  input  logic [5:0]   command_i,
  input  logic [3:0]   dst_reg_i,
  input  logic [3:0]   src_reg_i,
  input  logic [63:0]  immediate_i,
  input  logic [31:0]  slot_offset_i,
  input  logic         q_full_i,
  output logic         q_push_o,
  output desc_t        q_desc_o
);

  cmd_e                cmd;
  desc_t               desc;
  logic                use_slot;
  logic [3:0]          slot_reg;
  logic [1:0]          slot_mode;
  logic [ByteIdxW-1:0] slot_len;
  logic                imm_small;
  logic [3:0]          d;
  logic [3:0]          r;

  assign cmd       = cmd_e'(command_i);
  assign d         = dst_reg_i;
  assign r         = src_reg_i;
  assign imm_small = (&immediate_i[63:7]) | ~(|immediate_i[63:7]);

  always_comb begin
    if (slot_offset_i == 32'd0) begin
      slot_mode = 2'd0;
      slot_len  = ByteIdxW'(4);
    end else if (slot_offset_i <= Disp8Max) begin
      slot_mode = 2'd1;
      slot_len  = ByteIdxW'(5);
    end else begin
      slot_mode = 2'd2;
      slot_len  = ByteIdxW'(8);
    end
  end

  always_comb begin
    desc     = '0;
    use_slot = 1'b0;
    slot_reg = d;
    case (cmd)
      CMD_MOV_RR, CMD_MOV_R32, CMD_CMP_RR, CMD_ADD_RR, CMD_SUB_RR: begin
        desc.bytes[0] = rex(cmd != CMD_MOV_R32, r, d);
        case (cmd)
          CMD_CMP_RR: desc.bytes[1] = OpCmpStore;
          CMD_ADD_RR: desc.bytes[1] = OpAddStore;
          CMD_SUB_RR: desc.bytes[1] = OpSubStore;
          default:    desc.bytes[1] = OpMovStore;
        endcase
        desc.bytes[2] = modrm(2'd3, r[2:0], d[2:0]);
        desc.count    = ByteIdxW'(3);
      end
      CMD_MOV_R_STK, CMD_CMP_R_STK, CMD_LEA_STK: begin
        desc.bytes[0] = rex(1'b1, d, 4'd0);
        case (cmd)
          CMD_CMP_R_STK: desc.bytes[1] = OpCmpLoad;
          CMD_LEA_STK:   desc.bytes[1] = OpLea;
          default:       desc.bytes[1] = OpMovLoad;
        endcase
        use_slot = 1'b1;
      end
      CMD_MOV_STK_R: begin
        desc.bytes[0] = rex(1'b1, r, 4'd0);
        desc.bytes[1] = OpMovStore;
        use_slot      = 1'b1;
        slot_reg      = r;
      end
      CMD_MOV_R_PTR, CMD_MOV_R32_PTR, CMD_MOV_R64_PTR, CMD_MOVSXD: begin
        desc.bytes[0] = rex(cmd != CMD_MOV_R32_PTR, d, r);
        desc.bytes[1] = (cmd == CMD_MOVSXD) ? OpMovsxd : OpMovLoad;
        desc.bytes[2] = modrm((cmd == CMD_MOVSXD) ? 2'd3 : 2'd0, d[2:0], r[2:0]);
        desc.count    = ByteIdxW'(3);
      end
      CMD_MOV_R_IMM64: begin
        desc.bytes[0] = rex(1'b1, 4'd0, d);
        desc.bytes[1] = {OpMovImm[7:3], d[2:0]};
        for (int i = 0; i < 8; i++) begin
          desc.bytes[2+i] = immediate_i[8*i +: 8];
        end
        desc.count = ByteIdxW'(10);
      end
      CMD_MOV_PTR_R: begin
        desc.bytes[0] = rex(1'b1, r, d);
        desc.bytes[1] = OpMovStore;
        desc.bytes[2] = modrm(2'd0, r[2:0], d[2:0]);
        desc.count    = ByteIdxW'(3);
      end
      CMD_MOVZX_R8, CMD_MOVSX_R8, CMD_MOVZX_R16, CMD_MOVSX_R16, CMD_IMUL_RR,
      CMD_MOVZX_B_PTR, CMD_MOVZX_W_PTR: begin
        desc.bytes[0] = rex(1'b1, d, r);
        desc.bytes[1] = OpEscape;
        case (cmd)
          CMD_MOVSX_R8:  desc.bytes[2] = OpMovsxB;
          CMD_MOVZX_R16, CMD_MOVZX_W_PTR: desc.bytes[2] = OpMovzxW;
          CMD_MOVSX_R16: desc.bytes[2] = OpMovsxW;
          CMD_IMUL_RR:   desc.bytes[2] = OpImul2;
          default:       desc.bytes[2] = OpMovzxB;
        endcase
        desc.bytes[3] = modrm((cmd == CMD_MOVZX_B_PTR || cmd == CMD_MOVZX_W_PTR) ? 2'd0 : 2'd3,
                              d[2:0], r[2:0]);
        desc.count    = ByteIdxW'(4);
      end
      CMD_CMP_IMM8: begin
        desc.bytes[0] = rex(1'b1, 4'd0, d);
        desc.bytes[1] = OpAluImm8;
        desc.bytes[2] = modrm(2'd3, 3'd7, d[2:0]);
        desc.bytes[3] = immediate_i[7:0];
        desc.count    = ByteIdxW'(4);
      end
      CMD_CALL_R, CMD_IDIV: begin
        desc.bytes[0] = rex(1'b1, 4'd0, d);
        desc.bytes[1] = (cmd == CMD_IDIV) ? OpGrp3 : OpGrp5;
        desc.bytes[2] = modrm(2'd3, (cmd == CMD_IDIV) ? 3'd7 : 3'd2, d[2:0]);
        desc.count    = ByteIdxW'(3);
      end
      CMD_CALL_REL, CMD_JMP: begin
        desc.bytes[0] = (cmd == CMD_JMP) ? OpJmpRel : OpCallRel;
        desc.count    = ByteIdxW'(5);
        desc.rel_en   = 1'b1;
        desc.rel_pos  = ByteIdxW'(1);
      end
      CMD_SYSCALL: begin
        desc.bytes[0] = OpEscape;
        desc.bytes[1] = OpSyscall2;
        desc.count    = ByteIdxW'(2);
      end
      CMD_ADD_IMM, CMD_SUB_IMM: begin
        desc.bytes[0] = rex(1'b1, 4'd0, d);
        desc.bytes[1] = OpAluImm32;
        desc.bytes[2] = modrm(2'd3, (cmd == CMD_ADD_IMM) ? 3'd0 : 3'd5, d[2:0]);
        for (int i = 0; i < 4; i++) begin
          desc.bytes[3+i] = immediate_i[8*i +: 8];
        end
        desc.count = ByteIdxW'(7);
      end
      CMD_IMUL_IMM: begin
        desc.bytes[0] = rex(1'b1, d, d);
        desc.bytes[1] = imm_small ? OpImulImm8 : OpImulImm32;
        desc.bytes[2] = modrm(2'd3, d[2:0], d[2:0]);
        for (int i = 0; i < 4; i++) begin
          desc.bytes[3+i] = immediate_i[8*i +: 8];
        end
        desc.count = imm_small ? ByteIdxW'(4) : ByteIdxW'(7);
      end
      CMD_LEA_RIP: begin
        desc.bytes[0] = rex(1'b1, d, 4'd0);
        desc.bytes[1] = OpLea;
        desc.bytes[2] = modrm(2'd0, d[2:0], 3'd5);
        desc.count    = ByteIdxW'(7);
        desc.rel_en   = 1'b1;
        desc.rel_pos  = ByteIdxW'(3);
      end
      CMD_CQO: begin
        desc.bytes[0] = RexW;
        desc.bytes[1] = OpCqo;
        desc.count    = ByteIdxW'(2);
      end
      CMD_JE, CMD_JNE, CMD_JG, CMD_JGE, CMD_JL, CMD_JLE: begin
        desc.bytes[0] = OpEscape;
        case (cmd)
          CMD_JE:  desc.bytes[1] = OpJe;
          CMD_JNE: desc.bytes[1] = OpJne;
          CMD_JG:  desc.bytes[1] = OpJg;
          CMD_JGE: desc.bytes[1] = OpJge;
          CMD_JL:  desc.bytes[1] = OpJl;
          default: desc.bytes[1] = OpJle;
        endcase
        desc.count   = ByteIdxW'(6);
        desc.rel_en  = 1'b1;
        desc.rel_pos = ByteIdxW'(2);
      end
      CMD_RET: begin
        desc.bytes[0] = OpRet;
        desc.count    = ByteIdxW'(1);
      end
      default: begin
        desc = '0;
      end
    endcase

    if (use_slot) begin
      desc.bytes[2] = modrm(slot_mode, slot_reg[2:0], 3'd4);
      desc.bytes[3] = SibRsp;
      for (int i = 0; i < 4; i++) begin
        desc.bytes[4+i] = slot_offset_i[8*i +: 8];
      end
      desc.count = slot_len;
    end
  end

  // Unknown forms encode to nothing and are consumed without a queue entry.
  assign s_ready_o = ~q_full_i;
  assign q_push_o  = s_valid_i & ~q_full_i & (desc.count != '0);
  assign q_desc_o  = desc;

endmodule

@@ rtl/xenc_fifo.sv @@
// Short register queue of decoded instructions between the front and back ends.
module xenc_fifo
  import xenc_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output desc_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

@@ rtl/xenc_back.sv @@
// Back end: serializes the queued instruction one byte per beat into an output register.
module xenc_back
  import xenc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  desc_t      q_head_i,
  output logic       q_pop_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [7:0] m_byte_o,
  output logic       m_rel_o,
  output logic       m_last_o
);

  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic                valid_q, valid_d;
  logic [7:0]          byte_q;
  logic                rel_q;
  logic                last_q;
  logic                adv;
  logic                is_last;

  assign adv     = ~q_empty_i & (~valid_q | m_ready_i);
  assign is_last = (idx_q == q_head_i.count - ByteIdxW'(1));
  assign q_pop_o = adv & is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (adv) begin
      idx_d   = is_last ? '0 : idx_q + ByteIdxW'(1);
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= q_head_i.bytes[idx_q];
      rel_q  <= q_head_i.rel_en & (idx_q == q_head_i.rel_pos);
      last_q <= is_last;
    end
  end

  assign m_valid_o = valid_q;
  assign m_byte_o  = byte_q;
  assign m_rel_o   = rel_q;
  assign m_last_o  = last_q;

endmodule

@@ rtl/x86_64_instruction_encoder.sv @@
// Top level of the x86-64 instruction encoder: front decoder, queue and byte serializer.
// Usage:
// The slave channel takes one instruction per beat. tuser carries the form code, tdata the
// register numbers, the immediate and the RSP stack offset. The master channel returns the
// encoded instruction one byte per beat; tlast marks its final byte and tuser flags the first
// byte of a four-byte zero relocation slot. Forms without an encoding are accepted and give
// no bytes.
// Timing: a decoded instruction enters the queue at the accepting edge; the serializer then
// copies its first byte from the queue head into the output register, which presents it on
// the master channel. The serializer sends one byte per cycle while the receiver keeps tready
// high and moves straight on to the next queued instruction; an item has 1 to 10 bytes. The
// output byte rate sets the sustained throughput.
// Stalls: while the receiver holds tready low the output register keeps its beat, the queue
// of QueueDepth instructions fills and then the slave tready drops.
// Reset: clears the queue and the output valid; the slave tready is high from reset on, and
// beats are taken from the first edge after release.
module x86_64_instruction_encoder
  import xenc_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [103:0] s_axis_tdata_i,  // dst_reg[3:0], src_reg[7:4], immediate[71:8],
                                        // slot_offset[103:72]
  input  logic [5:0]   s_axis_tuser_i,  // command[5:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [7:0]   m_axis_tdata_o,  // code_byte[7:0]
  output logic         m_axis_tuser_o,  // relocation_start[0]
  output logic         m_axis_tlast_o
);

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  desc_t push_desc;
  desc_t head_desc;

  xenc_front u_front (
    .s_valid_i      (s_axis_tvalid_i),
    .s_ready_o      (s_axis_tready_o),
    .command_i      (s_axis_tuser_i),
    .dst_reg_i      (s_axis_tdata_i[3:0]),
    .src_reg_i      (s_axis_tdata_i[7:4]),
    .immediate_i    (s_axis_tdata_i[71:8]),
    .slot_offset_i  (s_axis_tdata_i[103:72]),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_desc_o       (push_desc)
  );

  xenc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_desc)
  );

  xenc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (head_desc),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_byte_o  (m_axis_tdata_o),
    .m_rel_o   (m_axis_tuser_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule
